// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

// ===== rtl/core/bmp_pkg.sv =====
// Package for battery_mv_to_percent: field widths, the discharge table and the
// per-segment rounding thresholds. Depends on nothing.
`timescale 1ns / 1ps

package bmp_pkg;

   // Field widths
   localparam int MV_W    = 13;
   localparam int PCT_W   = 7;
   localparam int VOLTS_W = 6;
   localparam int HALF_W  = 8;

   localparam logic [MV_W-1:0]   MV_MAX    = 13'd5000;
   localparam logic [PCT_W-1:0]  PCT_EMPTY = 7'd0;
   localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
   localparam logic [HALF_W-1:0] HALF_MAX  = 8'd200;

   // Discharge table, highest voltage first
   localparam int POINTS = 21;
   localparam int SEGS   = POINTS - 1;
   localparam int SEG_W  = $clog2(SEGS);
   localparam int LUT_MV [POINTS] = '{
      4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
      3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3300};
   localparam int LUT_PCT [POINTS] = '{
      100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
      45, 40, 35, 30, 25, 20, 15, 10, 5, 0};

   // Every segment rises by the same step in percent
   localparam int RISE = 5;
   // Distance above a segment's lower point; the widest segment is 310 mV
   localparam int D_W  = 9;

   typedef logic [RISE-1:0][D_W-1:0] thr_row_type;
   typedef thr_row_type [SEGS-1:0]   thr_table_type;

   // Rounded step: floor((2*d*RISE + span) / (2*span)) equals the number of k
   // in 0..RISE-1 with d >= ceil(span*(2k+1) / (2*RISE)).
   function automatic thr_table_type build_thresholds();
      thr_table_type t;
      int span;
      for (int s = 0; s < SEGS; s++) begin
         span = LUT_MV[s] - LUT_MV[s+1];
         for (int k = 0; k < RISE; k++) begin
            t[s][k] = D_W'((span * (2 * k + 1) + 2 * RISE - 1) / (2 * RISE));
         end
      end
      return t;
   endfunction

   localparam thr_table_type THRESH = build_thresholds();

   // Tenths of a volt: (mv + 50) / 100 as multiply by reciprocal and shift
   localparam logic [MV_W-1:0] VOLT_BIAS  = 13'd50;
   localparam logic [MV_W-1:0] VOLT_RECIP = 13'd5243;
   localparam int              VOLT_SHIFT = 19;
   localparam int              PROD_W     = 2 * MV_W;

   // Segment search result handed to the fraction stage
   typedef struct packed {
      logic             below;
      logic             above;
      logic [SEG_W-1:0] seg;
      logic [D_W-1:0]   delta;
   } seg_info_type;

endpackage

// ===== rtl/core/battery_mv_to_percent.sv =====
// Top level of the battery voltage to charge converter.
// Depends on bmp_pkg, bmp_seg_find, bmp_frac and bmp_volts.
`timescale 1ns / 1ps

// Usage
//   Input: drive req_battery_mv with start high; a transaction is taken at
//   each rising edge with start high and busy low. busy is always low, so a
//   new reading may be given every clock.
//   Output: rsp_valid is high for one cycle with rsp_charge_percent,
//   rsp_volts_tenths and rsp_percent_half_units. The receiver cannot stall;
//   results are never held and need none.
//   The result passes four register stages between the accepting edge and
//   the cycle with rsp_valid (input saturation, segment search plus
//   reciprocal multiply, rounding compares plus shift, output register).
//   Throughput: one reading per clock.
//   Readings above 5000 mV are saturated to 5000 mV.
//   Reset (synchronous, active high) clears the valid bits of every stage;
//   transactions in flight are dropped and no result comes out of them.
module battery_mv_to_percent (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bmp_pkg::MV_W-1:0]      req_battery_mv,
   output logic                          rsp_valid,
   output logic [bmp_pkg::PCT_W-1:0]     rsp_charge_percent,
   output logic [bmp_pkg::VOLTS_W-1:0]   rsp_volts_tenths,
   output logic [bmp_pkg::HALF_W-1:0]    rsp_percent_half_units
);

   logic                          accept;
   logic [bmp_pkg::MV_W-1:0]      mv_in;
   logic [bmp_pkg::MV_W-1:0]      mv_ff;
   logic [2:0]                    valid_in;
   logic [2:0]                    valid_ff;
   logic                          rsp_valid_ff;
   bmp_pkg::seg_info_type         seg_info;
   logic [bmp_pkg::PCT_W-1:0]     pct;
   logic [bmp_pkg::VOLTS_W-1:0]   volts;
   logic [bmp_pkg::HALF_W-1:0]    half_in;
   logic [bmp_pkg::PCT_W-1:0]     pct_ff;
   logic [bmp_pkg::VOLTS_W-1:0]   volts_ff;
   logic [bmp_pkg::HALF_W-1:0]    half_ff;

   // Pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Input stage: saturate the reading
   assign mv_in = (req_battery_mv > bmp_pkg::MV_MAX) ? bmp_pkg::MV_MAX : req_battery_mv;

   always_ff @(posedge clock) begin
      mv_ff <= mv_in;
   end

   bmp_seg_find u_seg_find (
      .clock  (clock),
      .mv_i   (mv_ff),
      .info_o (seg_info)
   );

   bmp_frac u_frac (
      .clock  (clock),
      .info_i (seg_info),
      .pct_o  (pct)
   );

   bmp_volts u_volts (
      .clock   (clock),
      .mv_i    (mv_ff),
      .volts_o (volts)
   );

   // Valid bits travel alongside the data stages
   assign valid_in = {valid_ff[1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[2];
      end
   end

   // Output stage: half-percent units, capped
   always_comb begin
      half_in = {pct, 1'b0};
      if (half_in > bmp_pkg::HALF_MAX) begin
         half_in = bmp_pkg::HALF_MAX;
      end
   end

   always_ff @(posedge clock) begin
      pct_ff   <= pct;
      volts_ff <= volts;
      half_ff  <= half_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_charge_percent     = pct_ff;
   assign rsp_volts_tenths       = volts_ff;
   assign rsp_percent_half_units = half_ff;

endmodule

// ===== rtl/core/bmp_seg_find.sv =====
// Segment search stage: finds the table segment of a voltage and the distance
// above its lower point. Depends on bmp_pkg.
`timescale 1ns / 1ps

module bmp_seg_find (
   input  logic                         clock,
   input  logic [bmp_pkg::MV_W-1:0]     mv_i,
   output bmp_pkg::seg_info_type        info_o
);

   logic [bmp_pkg::SEGS-1:0]   ge;
   logic [bmp_pkg::SEG_W-1:0]  seg;
   logic [bmp_pkg::MV_W-1:0]   lo_mv;
   logic [bmp_pkg::MV_W-1:0]   diff;
   bmp_pkg::seg_info_type      info_in;
   bmp_pkg::seg_info_type      info_ff;

   // Compare against every lower point, then take the highest segment hit
   always_comb begin
      for (int s = 0; s < bmp_pkg::SEGS; s++) begin
         ge[s] = (mv_i >= bmp_pkg::MV_W'(bmp_pkg::LUT_MV[s+1]));
      end
      seg   = '0;
      lo_mv = bmp_pkg::MV_W'(bmp_pkg::LUT_MV[bmp_pkg::SEGS]);
      for (int s = bmp_pkg::SEGS - 1; s >= 0; s--) begin
         if (ge[s]) begin
            seg   = bmp_pkg::SEG_W'(s);
            lo_mv = bmp_pkg::MV_W'(bmp_pkg::LUT_MV[s+1]);
         end
      end
      diff = mv_i - lo_mv;
      info_in.below = (mv_i <= bmp_pkg::MV_W'(bmp_pkg::LUT_MV[bmp_pkg::POINTS-1]));
      info_in.above = (mv_i >= bmp_pkg::MV_W'(bmp_pkg::LUT_MV[0]));
      info_in.seg   = seg;
      info_in.delta = diff[bmp_pkg::D_W-1:0];
   end

   always_ff @(posedge clock) begin
      info_ff <= info_in;
   end

   assign info_o = info_ff;

endmodule

// ===== rtl/core/bmp_frac.sv =====
// Fraction stage: rounds the step within a segment by threshold compares and
// adds the segment's lower percentage. Depends on bmp_pkg.
`timescale 1ns / 1ps

module bmp_frac (
   input  logic                         clock,
   input  bmp_pkg::seg_info_type        info_i,
   output logic [bmp_pkg::PCT_W-1:0]    pct_o
);

   logic [bmp_pkg::PCT_W-1:0] lo_pct;
   logic [bmp_pkg::PCT_W-1:0] step;
   logic [bmp_pkg::PCT_W-1:0] pct_in;
   logic [bmp_pkg::PCT_W-1:0] pct_ff;
   bmp_pkg::thr_row_type      row;

   // Count thresholds passed, select lower percentage of the segment
   always_comb begin
      row  = bmp_pkg::THRESH[info_i.seg];
      step = '0;
      for (int k = 0; k < bmp_pkg::RISE; k++) begin
         if (info_i.delta >= row[k]) begin
            step = step + 1'b1;
         end
      end
      lo_pct = bmp_pkg::PCT_EMPTY;
      for (int s = 0; s < bmp_pkg::SEGS; s++) begin
         if (info_i.seg == bmp_pkg::SEG_W'(s)) begin
            lo_pct = bmp_pkg::PCT_W'(bmp_pkg::LUT_PCT[s+1]);
         end
      end
      if (info_i.below) begin
         pct_in = bmp_pkg::PCT_EMPTY;
      end else if (info_i.above) begin
         pct_in = bmp_pkg::PCT_FULL;
      end else begin
         pct_in = lo_pct + step;
      end
   end

   always_ff @(posedge clock) begin
      pct_ff <= pct_in;
   end

   assign pct_o = pct_ff;

endmodule

// ===== rtl/core/bmp_volts.sv =====
// Voltage rounding to tenths of a volt: reciprocal multiply, then shift, over
// two register stages. Depends on bmp_pkg.
`timescale 1ns / 1ps

module bmp_volts (
   input  logic                         clock,
   input  logic [bmp_pkg::MV_W-1:0]     mv_i,
   output logic [bmp_pkg::VOLTS_W-1:0]  volts_o
);

   logic [bmp_pkg::MV_W-1:0]    biased;
   logic [bmp_pkg::PROD_W-1:0]  prod_in;
   logic [bmp_pkg::PROD_W-1:0]  prod_ff;
   logic [bmp_pkg::VOLTS_W-1:0] volts_ff;

   // mv is at most 5000, so mv + 50 fits the field width
   assign biased  = mv_i + bmp_pkg::VOLT_BIAS;
   assign prod_in = bmp_pkg::PROD_W'(biased) * bmp_pkg::PROD_W'(bmp_pkg::VOLT_RECIP);

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      volts_ff <= prod_ff[bmp_pkg::VOLT_SHIFT +: bmp_pkg::VOLTS_W];
   end

   assign volts_o = volts_ff;

endmodule

// ===== rtl/core/bmp_checker.sv =====
// Port-level checker for battery_mv_to_percent and its bind statement.
// Depends on bmp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [bmp_pkg::MV_W-1:0]      req_battery_mv,
   input logic                          rsp_valid,
   input logic [bmp_pkg::PCT_W-1:0]     rsp_charge_percent,
   input logic [bmp_pkg::VOLTS_W-1:0]   rsp_volts_tenths,
   input logic [bmp_pkg::HALF_W-1:0]    rsp_percent_half_units
);

   // Every accepted transaction gives a result
   `ASSERT_ALWAYS(a_latency, clock, reset, (start && !busy) |-> ##4 rsp_valid, "result missing")

   // No result without an earlier transaction
   `ASSERT_ALWAYS(a_no_spurious, clock, reset, rsp_valid |-> $past(start && !busy, 4), "spurious result")

   // Half units track the percentage
   `ASSERT_ALWAYS(a_half, clock, reset, rsp_valid |-> (rsp_charge_percent <= bmp_pkg::PCT_FULL && rsp_percent_half_units == {rsp_charge_percent, 1'b0}), "half units mismatch")

   // At or above the top table point the charge is full
   `ASSERT_ALWAYS(a_full, clock, reset, (rsp_valid && $past(req_battery_mv, 4) >= 13'd4200) |-> (rsp_charge_percent == bmp_pkg::PCT_FULL && rsp_volts_tenths >= 6'd42), "full range wrong")

   // At or below the bottom table point the charge is empty
   `ASSERT_NEVER(a_empty, clock, reset, rsp_valid && $past(req_battery_mv, 4) <= 13'd3300 && rsp_charge_percent != bmp_pkg::PCT_EMPTY, "empty range wrong")

endmodule

bind battery_mv_to_percent bmp_checker u_bmp_checker (.*);
